### sv/dpcm_pkg.sv
// dpcm_pkg: shared constants, item mode codes and the channel entry type
// for the delta sample player; no dependencies
package dpcm_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int BANK_BYTES   = 4096;
	localparam int NUM_BANKS    = 4;
	localparam int STORE_BYTES  = NUM_CHANNELS > 0 ? NUM_BANKS * BANK_BYTES : 1;

	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int LOG_CH = $clog2(NUM_CHANNELS);
	localparam int CH_W   = (LOG_CH > 0) ? LOG_CH : 1;
	localparam int SUM_W  = 8 + LOG_CH;

	localparam int SAT_HI = 127;
	localparam int SAT_LO = -128;
	localparam logic [7:0] MSB_FLIP = 8'h80;
	localparam logic [7:0] LVL_STEP = 8'h01;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_START = 2'd1,
		MODE_TICK  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [BANK_W-1:0] bank;
		logic [2:0]        pos;
		logic [7:0]        level;
	} chan_t;

endpackage

### sv/dpcm_multichannel_sample_player_unit.sv
// dpcm_multichannel_sample_player_unit: top level of the delta sample player
// depends on dpcm_pkg and dpcm_ram (sample store and channel state table)
//
//   channel  | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   in       | in_valid in_ready mode address data             | into block
//            | sample_number                                  |
//   out      | out_valid out_ready dac_code dac_changed        | from block
//            | start_accepted start_channel busy_mask         |
//
// write and start beats may follow back to back
// a tick reads one channel a cycle, then the sample store, writes back and
// saturates: its result is loaded into the output register from done_s3, and
// the next beat is taken only once done_s3 has cleared
// the result sits in an output register; input is held off only while a tick
// is in flight or the output register is full and not being taken
// reset clears the channel active bits, the last dac code and the handshakes
module dpcm_multichannel_sample_player_unit
	import dpcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [13:0] address,
	input  logic [7:0]  data,
	input  logic [1:0]  sample_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  dac_code,
	output logic        dac_changed,
	output logic        start_accepted,
	output logic [1:0]  start_channel,
	output logic [3:0]  busy_mask
);

	logic                    out_valid_q;
	logic [7:0]              dac_code_q;
	logic                    dac_changed_q;
	logic                    start_accepted_q;
	logic [1:0]              start_channel_q;
	logic [3:0]              busy_mask_q;
	logic [7:0]              last_code_q;
	logic [NUM_CHANNELS-1:0] active_q;

	logic                    tick_run_q;
	logic [CH_W-1:0]         rd_idx_q;
	logic                    valid_s1, last_s1;
	logic [CH_W-1:0]         idx_s1;
	logic                    valid_s2, last_s2;
	logic [CH_W-1:0]         idx_s2;
	chan_t                   chan_s2;
	logic                    done_s3;
	logic signed [SUM_W-1:0] sum_q;

	chan_t                   chan_rd;
	logic [7:0]              byte_rd;

	logic                    accept, tick_busy;
	logic                    is_write, is_start, is_tick, start_hit;
	logic                    free_found;
	logic [CH_W-1:0]         free_idx;
	logic [NUM_CHANNELS-1:0] active_start;
	chan_t                   chan_init;
	logic [BANK_W-1:0]       req_bank;

	logic                    bit_val, ch_live, at_end;
	logic [7:0]              lvl_n;
	logic [ADDR_W:0]         addr_next, bank_end;
	chan_t                   chan_wb;
	logic signed [SUM_W-1:0] contrib;

	logic                    cram_we;
	logic [CH_W-1:0]         cram_waddr;
	chan_t                   cram_wdata;

	logic [7:0]              code_s3;

	assign tick_busy = tick_run_q | valid_s1 | valid_s2 | done_s3;
	assign in_ready  = !tick_busy && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;

	always_comb begin
		is_write = 1'b0;
		is_start = 1'b0;
		is_tick  = 1'b0;
		unique case (mode_t'(mode))
			MODE_WRITE: is_write = accept;
			MODE_START: is_start = accept;
			MODE_TICK:  is_tick  = accept;
			default:    ;
		endcase
	end

	// lowest idle channel
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int c = NUM_CHANNELS - 1; c >= 0; c--) begin
			if (!active_q[c]) begin
				free_found = 1'b1;
				free_idx   = CH_W'(c);
			end
		end
	end

	assign start_hit = is_start && free_found;
	assign req_bank  = BANK_W'(sample_number % NUM_BANKS);

	always_comb begin
		active_start = active_q;
		if (start_hit) begin
			active_start[free_idx] = 1'b1;
		end
	end

	always_comb begin
		chan_init       = '0;
		chan_init.bank  = req_bank;
		chan_init.addr  = ADDR_W'(req_bank) * ADDR_W'(BANK_BYTES);
	end

	// channel step on the byte just read
	always_comb begin
		bit_val   = byte_rd[chan_s2.pos];
		lvl_n     = bit_val ? chan_s2.level + LVL_STEP : chan_s2.level - LVL_STEP;
		addr_next = {1'b0, chan_s2.addr} + (ADDR_W+1)'(1);
		bank_end  = ((ADDR_W+1)'(chan_s2.bank) + (ADDR_W+1)'(1))
			* (ADDR_W+1)'(BANK_BYTES);
		at_end    = (chan_s2.pos == 3'd7) && (addr_next >= bank_end);
		ch_live   = active_q[idx_s2];
		chan_wb   = chan_s2;
		if (at_end) begin
			chan_wb.addr  = '0;
			chan_wb.pos   = '0;
			chan_wb.level = '0;
		end else begin
			chan_wb.pos   = chan_s2.pos + 3'd1;
			chan_wb.level = lvl_n;
			if (chan_s2.pos == 3'd7) begin
				chan_wb.addr = addr_next[ADDR_W-1:0];
			end
		end
		contrib = (ch_live && !at_end) ? SUM_W'($signed(lvl_n)) : '0;
	end

	always_comb begin
		if (start_hit) begin
			cram_we    = 1'b1;
			cram_waddr = free_idx;
			cram_wdata = chan_init;
		end else begin
			cram_we    = valid_s2 && ch_live;
			cram_waddr = idx_s2;
			cram_wdata = chan_wb;
		end
	end

	dpcm_ram #(
		.WIDTH($bits(chan_t)),
		.DEPTH(NUM_CHANNELS)
	) u_chan_ram (
		.clk  (clk),
		.we   (cram_we),
		.waddr(cram_waddr),
		.wdata(cram_wdata),
		.raddr(rd_idx_q),
		.rdata(chan_rd)
	);

	dpcm_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_sample_ram (
		.clk  (clk),
		.we   (is_write),
		.waddr(ADDR_W'(address)),
		.wdata(data),
		.raddr(chan_rd.addr),
		.rdata(byte_rd)
	);

	// saturate and convert to offset binary
	always_comb begin
		if (sum_q > SUM_W'(SAT_HI)) begin
			code_s3 = 8'(SAT_HI);
		end else if (sum_q < SUM_W'(SAT_LO)) begin
			code_s3 = 8'(SAT_LO);
		end else begin
			code_s3 = sum_q[7:0];
		end
		code_s3 = code_s3 ^ MSB_FLIP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_code_q <= '0;
			active_q    <= '0;
			tick_run_q  <= 1'b0;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			idx_s1      <= '0;
			valid_s2    <= 1'b0;
			last_s2     <= 1'b0;
			idx_s2      <= '0;
			done_s3     <= 1'b0;
		end else begin
			if ((accept && !is_tick) || done_s3) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (done_s3) begin
				last_code_q <= code_s3;
			end

			if (start_hit) begin
				active_q <= active_start;
			end else if (valid_s2 && ch_live && at_end) begin
				active_q[idx_s2] <= 1'b0;
			end

			if (is_tick) begin
				tick_run_q <= 1'b1;
				rd_idx_q   <= '0;
			end else if (tick_run_q) begin
				if (rd_idx_q == CH_W'(NUM_CHANNELS - 1)) begin
					tick_run_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + CH_W'(1);
				end
			end

			valid_s1 <= tick_run_q;
			last_s1  <= tick_run_q && (rd_idx_q == CH_W'(NUM_CHANNELS - 1));
			idx_s1   <= rd_idx_q;
			valid_s2 <= valid_s1;
			last_s2  <= valid_s1 && last_s1;
			idx_s2   <= idx_s1;
			done_s3  <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		chan_s2 <= chan_rd;
		if (is_tick) begin
			sum_q <= '0;
		end else if (valid_s2) begin
			sum_q <= sum_q + contrib;
		end
		if (accept && !is_tick) begin
			dac_code_q       <= last_code_q;
			dac_changed_q    <= 1'b0;
			start_accepted_q <= start_hit;
			start_channel_q  <= start_hit ? 2'(free_idx) : 2'd0;
			busy_mask_q      <= 4'(active_start);
		end
		if (done_s3) begin
			dac_code_q       <= code_s3;
			dac_changed_q    <= code_s3 != last_code_q;
			start_accepted_q <= 1'b0;
			start_channel_q  <= 2'd0;
			busy_mask_q      <= 4'(active_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign dac_code       = dac_code_q;
	assign dac_changed    = dac_changed_q;
	assign start_accepted = start_accepted_q;
	assign start_channel  = start_channel_q;
	assign busy_mask      = busy_mask_q;

	// a finished tick always finds the output register empty
	assert property (@(posedge clk) disable iff (!arst_n)
		done_s3 |-> !out_valid_q)
		else $error("tick result with output register full");

	// no new beat while a tick is still in the channel pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		(tick_run_q || valid_s1 || valid_s2) |-> !in_ready)
		else $error("input taken during tick");

	// a started channel shows up busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		start_hit |=> active_q[$past(free_idx)])
		else $error("started channel not marked active");

	// the tick result is loaded exactly once, after the last read passes last_s2 into done_s3
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> ##1 done_s3)
		else $error("tick completion lost");

endmodule

### sv/dpcm_ram.sv
// dpcm_ram: generic simple dual-port ram, one write and one registered read
// no package dependencies
module dpcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### verif/sample_mix_checker.sv
`timescale 1ns / 100ps
// sample_mix_checker: watches both handshake channels of the delta sample player,
// keeps its own copy of the sample store and voices, and compares every output beat
// depends on dpcm_pkg
module sample_mix_checker
	import dpcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [13:0] address,
	input  logic [7:0]  data,
	input  logic [1:0]  sample_number,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  dac_code,
	input  logic        dac_changed,
	input  logic        start_accepted,
	input  logic [1:0]  start_channel,
	input  logic [3:0]  busy_mask,
	output int          fail_count,
	output int          pending,
	output int          ticks_seen,
	output int          starts_taken,
	output int          starts_dropped,
	output int          bank_ends,
	output int          clipped_mixes
);

	typedef struct {
		int unsigned       byte_addr;
		logic [BANK_W-1:0] bank;
		logic [2:0]        bit_pos;
		logic [7:0]        level;
		logic              playing;
	} voice_t;

	typedef struct packed {
		logic [7:0] code;
		logic       changed;
		logic       taken;
		logic [1:0] chan;
		logic [3:0] busy;
	} mix_beat_t;

	logic [7:0] sample_mem [STORE_BYTES];
	voice_t     voices [NUM_CHANNELS];
	logic [7:0] prev_code;
	mix_beat_t  mix_expected [$];

	function automatic void clear_voice(int c);
		voices[c].byte_addr = 0;
		voices[c].bit_pos   = '0;
		voices[c].level     = '0;
		voices[c].playing   = 1'b0;
	endfunction

	// one bit of one voice, returns its signed level for the mix
	function automatic int step_voice(int c);
		logic [7:0] cur;
		if (!voices[c].playing)
			return 0;
		cur = sample_mem[voices[c].byte_addr % STORE_BYTES];
		if (cur[voices[c].bit_pos])
			voices[c].level = voices[c].level + 8'd1;
		else
			voices[c].level = voices[c].level - 8'd1;
		voices[c].bit_pos = voices[c].bit_pos + 3'd1;
		if (voices[c].bit_pos == 3'd0)
			voices[c].byte_addr++;
		if (voices[c].byte_addr >= (int'(voices[c].bank) + 1) * BANK_BYTES) begin
			clear_voice(c);
			bank_ends++;
		end
		return int'($signed(voices[c].level));
	endfunction

	task automatic predict_beat(logic [1:0] m, logic [13:0] a, logic [7:0] d, logic [1:0] s);
		mix_beat_t r;
		int        sum;
		logic      found;
		r = '0;
		found = 1'b0;
		case (m)
		MODE_WRITE: begin
			sample_mem[a % STORE_BYTES] = d;
		end
		MODE_START: begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				if (!found && !voices[c].playing) begin
					found = 1'b1;
					voices[c].playing   = 1'b1;
					voices[c].bank      = BANK_W'(int'(s) % NUM_BANKS);
					voices[c].byte_addr = (int'(s) % NUM_BANKS) * BANK_BYTES;
					voices[c].bit_pos   = '0;
					voices[c].level     = '0;
					r.taken = 1'b1;
					r.chan  = 2'(c);
				end
			end
			if (found)
				starts_taken++;
			else
				starts_dropped++;
		end
		MODE_TICK: begin
			sum = 0;
			for (int c = 0; c < NUM_CHANNELS; c++)
				sum += step_voice(c);
			if (sum > SAT_HI) begin
				sum = SAT_HI;
				clipped_mixes++;
			end else if (sum < SAT_LO) begin
				sum = SAT_LO;
				clipped_mixes++;
			end
			r.code    = 8'(sum) ^ MSB_FLIP;
			r.changed = (r.code != prev_code);
			prev_code = r.code;
			ticks_seen++;
		end
		default: begin
		end
		endcase
		r.code = prev_code;
		for (int c = 0; c < NUM_CHANNELS; c++)
			r.busy[c] = voices[c].playing;
		mix_expected.push_back(r);
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_beat();
		mix_beat_t e;
		if (mix_expected.size() == 0) begin
			$error("output beat with no input beat waiting for it");
			fail_count++;
			return;
		end
		e = mix_expected.pop_front();
		check_field("dac_code", e.code, dac_code);
		check_field("dac_changed", e.changed, dac_changed);
		check_field("start_accepted", e.taken, start_accepted);
		check_field("start_channel", e.chan, start_channel);
		check_field("busy_mask", e.busy, busy_mask);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				clear_voice(c);
				voices[c].bank = '0;
			end
			prev_code = '0;
			mix_expected.delete();
			fail_count     = 0;
			ticks_seen     = 0;
			starts_taken   = 0;
			starts_dropped = 0;
			bank_ends      = 0;
			clipped_mixes  = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready)
				check_beat();
			if (in_valid && in_ready)
				predict_beat(mode, address, data, sample_number);
			pending <= mix_expected.size();
		end
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// testbench: preloads the head of every bank, then drives directed and random
// beats into the delta sample player and reports the verdict
// depends on dpcm_pkg, dpcm_multichannel_sample_player_unit and sample_mix_checker
module testbench;
	import dpcm_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int RANDOM_BEATS   = 1050;
	localparam int PRELOAD_BYTES  = 96;
	// a voice never reads past the preloaded head of its bank
	localparam int TICK_BUDGET    = PRELOAD_BYTES * 8;
	localparam int TAIL_CYCLES    = 32;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic [1:0]  mode          = MODE_WRITE;
	logic [13:0] address       = '0;
	logic [7:0]  data          = '0;
	logic [1:0]  sample_number = '0;
	logic        out_ready     = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [7:0]  dac_code;
	logic        dac_changed;
	logic        start_accepted;
	logic [1:0]  start_channel;
	logic [3:0]  busy_mask;

	int fail_count, pending, ticks_seen, starts_taken, starts_dropped;
	int bank_ends, clipped_mixes;
	int cycle_count = 0;
	int beats_sent  = 0;
	int ticks_sent  = 0;
	int idle_pct    = 20;
	int stall_left  = 0;

	dpcm_multichannel_sample_player_unit u_dut (.*);

	sample_mix_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			stall_left <= gap_len() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_beat(logic [1:0] m, logic [13:0] a, logic [7:0] d, logic [1:0] s);
		in_valid      <= 1'b1;
		mode          <= m;
		address       <= a;
		data          <= d;
		sample_number <= s;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		if (m == MODE_TICK)
			ticks_sent++;
	endtask

	task automatic idle_gap();
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	task automatic beat(logic [1:0] m, logic [13:0] a, logic [7:0] d, logic [1:0] s);
		send_beat(m, a, d, s);
		idle_gap();
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic rand_beat(logic [1:0] m);
		beat(m, 14'($urandom), 8'($urandom), 2'($urandom));
	endtask

	// runs of rising, falling and noisy bytes so levels wrap and the mix clips
	task automatic preload_store();
		logic [7:0] fill;
		int         pick;
		pick = 0;
		for (int b = 0; b < NUM_BANKS; b++) begin
			for (int o = 0; o < PRELOAD_BYTES; o++) begin
				if (o % 32 == 0)
					pick = $urandom_range(0, 9);
				if (pick < 4)
					fill = 8'hFF;
				else if (pick < 7)
					fill = 8'h00;
				else
					fill = 8'($urandom);
				beat(MODE_WRITE, 14'(b * BANK_BYTES + o), fill, 2'($urandom));
			end
		end
	endtask

	task automatic directed_beats();
		beat(MODE_TICK, 14'h0000, 8'h00, 2'd0);
		beat(MODE_TICK, 14'h3FFF, 8'hFF, 2'd3);
		beat(MODE_WRITE, 14'h0000, 8'h00, 2'd0);
		beat(MODE_WRITE, 14'h3FFF, 8'hFF, 2'd3);
		beat(MODE_UNUSED, 14'h3FFF, 8'hFF, 2'd3);
		beat(MODE_START, 14'h0000, 8'h00, 2'd0);
		repeat (3) beat(MODE_TICK, 14'h0000, 8'h00, 2'd0);
		beat(MODE_START, 14'h2AAA, 8'h55, 2'd1);
		beat(MODE_START, 14'h1555, 8'hAA, 2'd2);
		beat(MODE_START, 14'h3FFF, 8'hFF, 2'd3);
		// every voice busy, this one is dropped
		beat(MODE_START, 14'h0000, 8'h00, 2'd2);
		repeat (4) beat(MODE_TICK, 14'h0000, 8'h00, 2'd0);
		beat(MODE_WRITE, 14'h1000, 8'hFF, 2'd1);
		beat(MODE_UNUSED, 14'h0000, 8'h00, 2'd0);
		repeat (2) beat(MODE_TICK, 14'h3FFF, 8'hFF, 2'd3);
	endtask

	task automatic random_beats();
		int counted;
		int r;
		counted = 0;
		while (counted < RANDOM_BEATS) begin
			if (counted % 100 == 0) begin
				r = $urandom_range(0, 2);
				idle_pct = (r == 0) ? 0 : (r == 1) ? 10 : 35;
			end
			r = $urandom_range(0, 99);
			if (r < 45 && ticks_sent < TICK_BUDGET)
				rand_beat(MODE_TICK);
			else if (r < 75)
				rand_beat(MODE_WRITE);
			else if (r < 90)
				rand_beat(MODE_START);
			else
				rand_beat(MODE_UNUSED);
			if (r < 90)
				counted++;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 10;
		preload_store();
		idle_pct = 35;
		directed_beats();
		wait_drained();
		random_beats();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d beats: %0d ticks, %0d starts taken, %0d starts dropped",
			beats_sent, ticks_seen, starts_taken, starts_dropped);
		$display("voices reached bank end %0d times, mix clipped on %0d ticks, %0d cycles",
			bank_ends, clipped_mixes, cycle_count);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
